### hw/rtl/assert_macros.svh
// Assertion macros, included by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

### hw/rtl/atqd_pkg.sv
// Constants of the adaptive threshold quadrature decoder.
package atqd_pkg;
    localparam int unsigned CFG_IDX_BITS = 1;
    localparam int unsigned CFG_DATA_BITS = 10;
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HYSTERESIS = 1'd1;
    localparam logic [9:0] RANGE_LIMIT_RESET = 10'd10;
    localparam logic [2:0] HYSTERESIS_RESET = 3'd2;
    localparam logic [1:0] PHASE_HIHI = 2'd3;
endpackage

### hw/rtl/atqd_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
module atqd_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hw/rtl/adaptive_threshold_quadrature_decoder.sv
// Adaptive threshold quadrature decoder: one sample pair in, one step and
// two thresholds out per transfer. Items are handled one at a time: a transfer
// is taken only in the idle state. The two history rings of each channel live
// in one RAM with one read a cycle. While a channel is still adapting, its
// threshold update does three things. It walks the stored entries of each
// ring, one entry a cycle. It runs a bit-serial divide by the entry count for
// each average. The divide by three is a reciprocal multiply and is done
// combinationally in the S_DIV3 state. The two channels are handled in turn.
// Once both rings of a channel are full, its threshold freezes and that
// channel only passes through S_TRACK and S_NEXT. Each transfer also passes
// through the idle, slice and output states. The result sits in an output
// register. The next transfer is taken while the result waits, but its slice
// step stalls until the waiting result has gone.
module adaptive_threshold_quadrature_decoder #(
    parameter int HISTORY_DEPTH = 8,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [atqd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [atqd_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // sample_a, sample_b, zero fill
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // step, threshold_a, threshold_b, zero fill
    output logic [((2+2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata
);
    `include "assert_macros.svh"

    localparam int SB = SAMPLE_BITS;
    localparam int HD = HISTORY_DEPTH;
    localparam int IB = (HD > 1) ? $clog2(HD) : 1;
    localparam int CB = $clog2(HD + 1);
    localparam int AB = IB + 2;
    localparam int SUMB = SB + CB;
    localparam int OW = ((2 + 2 * SB + 7) / 8) * 8;
    localparam int RW = (SB >= 10) ? SB + 1 : 11;
    localparam logic [SB-1:0] SMAX = {SB{1'b1}};
    // divide by three: x * M3 >> K3, exact for x below 2**(K3-1)
    localparam int K3 = 2 * ((SB + 3) / 2);
    localparam logic [K3-2:0] M3 = (K3-1)'(((1 << K3) + 2) / 3);

    typedef enum logic [3:0] {
        S_IDLE, S_TRACK, S_READ, S_ACC, S_DIV, S_DIV3, S_NEXT, S_SLICE, S_OUT
    } state_t;

    function automatic logic [SB-1:0] div3(input logic [SB:0] x);
        logic [SB+K3-1:0] p;
        p = (SB+K3)'(x) * (SB+K3)'(M3);
        return p[SB+K3-1:K3];
    endfunction

    // configuration
    logic [9:0] range_limit_reg;
    logic [2:0] hysteresis_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_limit_reg <= atqd_pkg::RANGE_LIMIT_RESET;
            hysteresis_reg <= atqd_pkg::HYSTERESIS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == atqd_pkg::REG_RANGE_LIMIT)
            begin
                range_limit_reg <= cfg_data[9:0];
            end
            else if (cfg_index == atqd_pkg::REG_HYSTERESIS)
            begin
                hysteresis_reg <= cfg_data[2:0];
            end
        end
    end

    // history RAM: address {chan, ring(0 low,1 high), entry}
    logic            ram_we;
    logic [AB-1:0]   ram_waddr, ram_raddr;
    logic [SB-1:0]   ram_wdata, ram_rdata;
    atqd_ram #(.WIDTH(SB), .DEPTH(1 << AB)) u_hist (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    state_t          state_reg;
    logic            chan_reg;
    logic            ring_reg;
    logic [SB-1:0]   cur_reg [2];
    logic [SB-1:0]   lo_reg [2], hi_reg [2], thr_reg [2];
    logic            arml_reg [2], armh_reg [2], lfull_reg [2], hfull_reg [2];
    logic [IB-1:0]   lidx_reg [2], hidx_reg [2];
    logic [1:0]      phase_reg;
    logic signed [3:0] accum_reg;
    logic [CB-1:0]   cnt_reg;       // entries summed so far
    logic [CB-1:0]   n_reg;         // entries in ring
    logic [SUMB-1:0] sum_reg;
    logic [SUMB-1:0] quo_reg;
    logic [SUMB:0]   rem_reg;
    logic [5:0]      bit_reg;
    logic [SB-1:0]   avg_reg [2];   // [0] low average, [1] high average
    logic            neg_reg;
    logic            m_valid_reg;
    logic [OW-1:0]   m_data_reg;

    // tracking of current channel
    logic            c;
    logic [SB-1:0]   cs, lo1, hi1, lvl, mid;
    logic [SB:0]     spread;
    logic            upd;
    assign c = chan_reg;
    assign cs = cur_reg[c];
    assign lo1 = (cs < lo_reg[c]) ? cs : lo_reg[c];
    assign hi1 = (cs > hi_reg[c]) ? cs : hi_reg[c];
    assign lvl = div3({1'b0, hi1} - {1'b0, lo1}) + lo1;
    assign mid = SB'((({1'b0, hi1} - {1'b0, lo1}) >> 1)) + lo1;
    assign spread = {1'b0, hi1} - {1'b0, lo1};
    assign upd = !(lfull_reg[c] && hfull_reg[c]);

    // ring entry counts
    logic [CB-1:0] nring;
    assign nring = ring_reg ? (hfull_reg[c] ? CB'(HD) : CB'(hidx_reg[c]))
                            : (lfull_reg[c] ? CB'(HD) : CB'(lidx_reg[c]));

    // divide-by-three on the signed threshold difference
    logic [SB:0] dmag;
    assign dmag = (avg_reg[1] >= avg_reg[0]) ? ({1'b0, avg_reg[1]} - {1'b0, avg_reg[0]})
                                             : ({1'b0, avg_reg[0]} - {1'b0, avg_reg[1]});

    // quadrature decode
    logic          ba, bb;
    logic [1:0]    nph, cwn, ccwn;
    logic signed [3:0] acc1;
    assign ba = !(cur_reg[0] < thr_reg[0]);
    assign bb = !(cur_reg[1] < thr_reg[1]);
    assign nph = {ba, bb};
    always_comb
    begin
        case (phase_reg)
            2'd0:    begin cwn = 2'd2; ccwn = 2'd1; end
            2'd1:    begin cwn = 2'd0; ccwn = 2'd3; end
            2'd2:    begin cwn = 2'd3; ccwn = 2'd0; end
            default: begin cwn = 2'd1; ccwn = 2'd2; end
        endcase
        acc1 = accum_reg;
        if (nph == cwn)
        begin
            acc1 = accum_reg + 4'sd1;
        end
        else if (nph == ccwn)
        begin
            acc1 = accum_reg - 4'sd1;
        end
    end
    logic signed [3:0] hys_s;
    assign hys_s = signed'({1'b0, hysteresis_reg});

    // RAM control
    logic rec_hi, rec_lo, crossing_ok;
    assign crossing_ok = (RW'(spread) >= RW'(range_limit_reg));
    assign rec_hi = crossing_ok && (cs < lvl) && armh_reg[c];
    assign rec_lo = crossing_ok && (cs > lvl) && arml_reg[c];
    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = {c, 1'b1, hidx_reg[c]};
        ram_wdata = hi1;
        if (state_reg == S_TRACK && upd)
        begin
            if (rec_hi)
            begin
                ram_we = 1'b1;
            end
            else if (rec_lo)
            begin
                ram_we = 1'b1;
                ram_waddr = {c, 1'b0, lidx_reg[c]};
                ram_wdata = lo1;
            end
        end
        ram_raddr = {c, ring_reg, cnt_reg[IB-1:0]};
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            chan_reg <= 1'b0;
            ring_reg <= 1'b0;
            phase_reg <= atqd_pkg::PHASE_HIHI;
            accum_reg <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg <= '0;
            cnt_reg <= '0;
            n_reg <= '0;
            sum_reg <= '0;
            quo_reg <= '0;
            rem_reg <= '0;
            bit_reg <= '0;
            neg_reg <= 1'b0;
            for (int k = 0; k < 2; k++)
            begin
                cur_reg[k] <= '0;
                avg_reg[k] <= '0;
                lo_reg[k] <= SMAX;
                hi_reg[k] <= '0;
                thr_reg[k] <= '0;
                arml_reg[k] <= 1'b0;
                armh_reg[k] <= 1'b0;
                lfull_reg[k] <= 1'b0;
                hfull_reg[k] <= 1'b0;
                lidx_reg[k] <= '0;
                hidx_reg[k] <= '0;
            end
        end
        else
        begin
            // output register: data loaded in S_SLICE, valid set in S_OUT, clear on transfer
            if (state_reg == S_OUT && (!m_valid_reg || m_tready))
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cur_reg[0] <= s_tdata[SB-1:0];
                        cur_reg[1] <= s_tdata[2*SB-1:SB];
                        chan_reg <= 1'b0;
                        state_reg <= S_TRACK;
                    end
                end
                S_TRACK:
                begin
                    if (!upd)
                    begin
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        // a recorded crossing collapses min and max to the midpoint
                        lo_reg[c] <= (rec_hi || rec_lo) ? mid : lo1;
                        hi_reg[c] <= (rec_hi || rec_lo) ? mid : hi1;
                        if (crossing_ok && cs < lvl && !armh_reg[c])
                        begin
                            arml_reg[c] <= 1'b1;
                        end
                        if (rec_hi)
                        begin
                            if (hidx_reg[c] == IB'(HD - 1))
                            begin
                                hidx_reg[c] <= '0;
                                hfull_reg[c] <= 1'b1;
                            end
                            else
                            begin
                                hidx_reg[c] <= hidx_reg[c] + IB'(1);
                            end
                            arml_reg[c] <= 1'b0;
                            armh_reg[c] <= 1'b0;
                        end
                        else if (crossing_ok && cs > lvl)
                        begin
                            if (arml_reg[c])
                            begin
                                // armed low: record trough
                                if (lidx_reg[c] == IB'(HD - 1))
                                begin
                                    lidx_reg[c] <= '0;
                                    lfull_reg[c] <= 1'b1;
                                end
                                else
                                begin
                                    lidx_reg[c] <= lidx_reg[c] + IB'(1);
                                end
                                arml_reg[c] <= 1'b0;
                                armh_reg[c] <= 1'b0;
                            end
                            else
                            begin
                                armh_reg[c] <= 1'b1;
                            end
                        end
                        ring_reg <= 1'b0;
                        cnt_reg <= '0;
                        sum_reg <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    // n for this ring; empty ring falls back to seen value
                    n_reg <= nring;
                    if (nring == '0)
                    begin
                        avg_reg[ring_reg] <= ring_reg ? hi_reg[c] : lo_reg[c];
                        if (ring_reg)
                        begin
                            state_reg <= S_DIV3;
                        end
                        else
                        begin
                            ring_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CB'(1);
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    sum_reg <= sum_reg + SUMB'(ram_rdata);
                    if (cnt_reg == n_reg)
                    begin
                        rem_reg <= '0;
                        quo_reg <= '0;
                        bit_reg <= 6'(SUMB);
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CB'(1);
                    end
                end
                S_DIV:
                begin
                    if (bit_reg == '0)
                    begin
                        avg_reg[ring_reg] <= quo_reg[SB-1:0];
                        cnt_reg <= '0;
                        sum_reg <= '0;
                        if (ring_reg)
                        begin
                            state_reg <= S_DIV3;
                        end
                        else
                        begin
                            ring_reg <= 1'b1;
                            state_reg <= S_READ;
                        end
                    end
                    else
                    begin
                        logic [SUMB:0] r2;
                        r2 = {rem_reg[SUMB-1:0], sum_reg[SUMB-1]};
                        sum_reg <= {sum_reg[SUMB-2:0], 1'b0};
                        if (r2 >= (SUMB+1)'(n_reg))
                        begin
                            rem_reg <= r2 - (SUMB+1)'(n_reg);
                            quo_reg <= {quo_reg[SUMB-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= r2;
                            quo_reg <= {quo_reg[SUMB-2:0], 1'b0};
                        end
                        bit_reg <= bit_reg - 6'd1;
                    end
                end
                S_DIV3:
                begin
                    if (avg_reg[1] >= avg_reg[0])
                    begin
                        thr_reg[c] <= avg_reg[0] + div3(dmag);
                    end
                    else
                    begin
                        thr_reg[c] <= avg_reg[0] - div3(dmag);
                    end
                    state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    if (c)
                    begin
                        state_reg <= S_SLICE;
                    end
                    else
                    begin
                        chan_reg <= 1'b1;
                        state_reg <= S_TRACK;
                    end
                end
                S_SLICE:
                begin
                    // wait until the previous result has left the output register
                    if (!m_valid_reg || m_tready)
                    begin
                        phase_reg <= nph;
                        if (acc1 >= hys_s)
                        begin
                            accum_reg <= '0;
                            neg_reg <= 1'b0;
                            m_data_reg <= OW'({thr_reg[1], thr_reg[0], 2'b01});
                        end
                        else if (-acc1 >= hys_s)
                        begin
                            accum_reg <= '0;
                            neg_reg <= 1'b1;
                            m_data_reg <= OW'({thr_reg[1], thr_reg[0], 2'b11});
                        end
                        else
                        begin
                            accum_reg <= acc1;
                            neg_reg <= 1'b0;
                            m_data_reg <= OW'({thr_reg[1], thr_reg[0], 2'b00});
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_IMPLY(a_acc_range, clk, rst_n, 1'b1, (accum_reg <= 4'sd7) && (accum_reg >= -4'sd7))
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_valid_reg && !m_tready, m_valid_reg)
    `ASSERT_IMPLY(a_neg_step, clk, rst_n, state_reg == S_OUT && neg_reg, m_data_reg[1:0] == 2'b11)
endmodule
